// File: src/fgbe_pkg.sv
package fgbe_pkg;

    // Datapath widths
    localparam int ANGLE_W    = 24;
    localparam int SUM_W      = 32;
    localparam int TIME_W     = 21;
    localparam int IMU_DT_W   = 16;
    localparam int FLOW_W     = 26;
    localparam int DT_W       = 20;
    localparam int LIMIT_W    = 25;
    localparam int GAIN_W     = 17;
    localparam int BIAS_W     = 26;

    localparam int NUM_LANES  = 2;

    // Divider: |angle| * 1e6 fits in 52 bits, divisor is at most 20 bits
    localparam int DIVD_W             = 52;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = DIVD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic [DT_W-1:0]   USEC_PER_SEC = 20'd1000000;
    localparam logic [GAIN_W-1:0] Q16_ONE      = 17'd65536;

    // APB register map
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RESET_INTERVAL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MATCH_TOL      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPIKE_LIMIT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_GAIN    = 3'd4;

    localparam logic [DT_W-1:0]    RST_RESET_INTERVAL = 20'd1000000;
    localparam logic [DT_W-1:0]    RST_MATCH_TOL      = 20'd50000;
    localparam logic [DT_W-1:0]    RST_MIN_INTERVAL   = 20'd10000;
    localparam logic [LIMIT_W-1:0] RST_SPIKE_LIMIT    = 25'd1677722;
    localparam logic [GAIN_W-1:0]  RST_FILTER_GAIN    = 17'd655;

    typedef struct packed {
        logic signed [SUM_W-1:0]  sum_angle;
        logic signed [FLOW_W-1:0] flow_angle;
        logic        [DT_W-1:0]   dt_imu;
        logic        [DT_W-1:0]   dt_flow;
        logic signed [BIAS_W-1:0] bias;
    } t_lane_req;

    typedef struct packed {
        logic [LIMIT_W-1:0] spike_limit;
        logic [GAIN_W-1:0]  filter_gain;
    } t_lane_cfg;

endpackage

// File: src/flow_gyro_bias_estimator.sv
// Path: an input transfer enters a check state and goes straight to the done
//   state when no bias update runs, or through the lanes and the radix-4
//   dividers in each lane when it does.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result is loaded into the output register, which may still be waiting.
// Reset: synchronous, active low; accumulators and bias clear to zero and the
//   configuration registers return to their defaults.
module flow_gyro_bias_estimator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [fgbe_pkg::ANGLE_W-1:0]    i_imu_angle_x,
    input  logic signed [fgbe_pkg::ANGLE_W-1:0]    i_imu_angle_y,
    input  logic        [fgbe_pkg::IMU_DT_W-1:0]   i_imu_interval_us,
    input  logic                                   i_flow_present,
    input  logic signed [fgbe_pkg::FLOW_W-1:0]     i_flow_angle_x,
    input  logic signed [fgbe_pkg::FLOW_W-1:0]     i_flow_angle_y,
    input  logic        [fgbe_pkg::DT_W-1:0]       i_flow_interval_us,

    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [fgbe_pkg::BIAS_W-1:0]     o_bias_x,
    output logic signed [fgbe_pkg::BIAS_W-1:0]     o_bias_y,
    output logic                                   o_bias_updated,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fgbe_pkg::PADDR_W-1:0]           paddr,
    input  logic [fgbe_pkg::PDATA_W-1:0]           pwdata,
    output logic [fgbe_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DONE
    } t_state;

    // configuration
    logic [fgbe_pkg::DT_W-1:0]     r_reset_interval;
    logic [fgbe_pkg::DT_W-1:0]     r_match_tol;
    logic [fgbe_pkg::DT_W-1:0]     r_min_interval;
    logic [fgbe_pkg::LIMIT_W-1:0]  r_spike_limit;
    logic [fgbe_pkg::GAIN_W-1:0]   r_filter_gain;
    logic [fgbe_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                          w_cfg_wr;

    t_state                                r_state;
    logic signed [fgbe_pkg::SUM_W-1:0]     r_sum_x;
    logic signed [fgbe_pkg::SUM_W-1:0]     r_sum_y;
    logic        [fgbe_pkg::TIME_W-1:0]    r_sum_time;
    logic signed [fgbe_pkg::BIAS_W-1:0]    r_bias_x;
    logic signed [fgbe_pkg::BIAS_W-1:0]    r_bias_y;
    logic                                  r_upd;
    logic                                  r_flow_present;
    logic signed [fgbe_pkg::FLOW_W-1:0]    r_flow_x;
    logic signed [fgbe_pkg::FLOW_W-1:0]    r_flow_y;
    logic        [fgbe_pkg::DT_W-1:0]      r_flow_dt;
    logic                                  r_out_valid;
    logic signed [fgbe_pkg::BIAS_W-1:0]    r_out_bias_x;
    logic signed [fgbe_pkg::BIAS_W-1:0]    r_out_bias_y;
    logic                                  r_out_upd;

    logic                                  w_in_xfer;
    logic signed [fgbe_pkg::SUM_W-1:0]     w_add_x;
    logic signed [fgbe_pkg::SUM_W-1:0]     w_add_y;
    logic        [fgbe_pkg::TIME_W-1:0]    w_add_t;
    logic                                  w_over;
    logic signed [fgbe_pkg::TIME_W:0]      w_tdiff;
    logic        [fgbe_pkg::TIME_W:0]      w_tabs;
    logic                                  w_pass;
    logic                                  w_start;

    fgbe_pkg::t_lane_req                   w_req   [fgbe_pkg::NUM_LANES];
    fgbe_pkg::t_lane_cfg                   w_cfg;
    logic signed [fgbe_pkg::BIAS_W-1:0]    w_lane_bias [fgbe_pkg::NUM_LANES];
    logic [fgbe_pkg::NUM_LANES-1:0]        w_lane_done;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    assign w_reg_idx = paddr[fgbe_pkg::PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_interval <= fgbe_pkg::RST_RESET_INTERVAL;
            r_match_tol      <= fgbe_pkg::RST_MATCH_TOL;
            r_min_interval   <= fgbe_pkg::RST_MIN_INTERVAL;
            r_spike_limit    <= fgbe_pkg::RST_SPIKE_LIMIT;
            r_filter_gain    <= fgbe_pkg::RST_FILTER_GAIN;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                fgbe_pkg::REG_RESET_INTERVAL: begin
                    r_reset_interval <= pwdata[fgbe_pkg::DT_W-1:0];
                end
                fgbe_pkg::REG_MATCH_TOL: begin
                    r_match_tol <= pwdata[fgbe_pkg::DT_W-1:0];
                end
                fgbe_pkg::REG_MIN_INTERVAL: begin
                    r_min_interval <= pwdata[fgbe_pkg::DT_W-1:0];
                end
                fgbe_pkg::REG_SPIKE_LIMIT: begin
                    r_spike_limit <= pwdata[fgbe_pkg::LIMIT_W-1:0];
                end
                fgbe_pkg::REG_FILTER_GAIN: begin
                    r_filter_gain <= pwdata[fgbe_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            fgbe_pkg::REG_RESET_INTERVAL: prdata = fgbe_pkg::PDATA_W'(r_reset_interval);
            fgbe_pkg::REG_MATCH_TOL:      prdata = fgbe_pkg::PDATA_W'(r_match_tol);
            fgbe_pkg::REG_MIN_INTERVAL:   prdata = fgbe_pkg::PDATA_W'(r_min_interval);
            fgbe_pkg::REG_SPIKE_LIMIT:    prdata = fgbe_pkg::PDATA_W'(r_spike_limit);
            fgbe_pkg::REG_FILTER_GAIN:    prdata = fgbe_pkg::PDATA_W'(r_filter_gain);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Accumulation and interval checks
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    assign w_add_x = r_sum_x + fgbe_pkg::SUM_W'(i_imu_angle_x);
    assign w_add_y = r_sum_y + fgbe_pkg::SUM_W'(i_imu_angle_y);
    assign w_add_t = r_sum_time + fgbe_pkg::TIME_W'(i_imu_interval_us);
    assign w_over  = w_add_t > fgbe_pkg::TIME_W'(r_reset_interval);

    assign w_tdiff = $signed({1'b0, r_sum_time})
                   - $signed({2'b0, r_flow_dt});
    assign w_tabs  = w_tdiff[fgbe_pkg::TIME_W] ? (fgbe_pkg::TIME_W+1)'(-w_tdiff)
                                               : w_tdiff;
    assign w_pass  = (w_tabs < (fgbe_pkg::TIME_W+1)'(r_match_tol))
                  && (r_sum_time > fgbe_pkg::TIME_W'(r_min_interval))
                  && (r_flow_dt > r_min_interval);

    // lanes latch their operands at the edge that clears the accumulators
    assign w_start = (r_state == S_CHECK) && r_flow_present && w_pass;

    // ------------------------------------------------------------------
    // One lane per axis
    // ------------------------------------------------------------------
    assign w_cfg.spike_limit = r_spike_limit;
    assign w_cfg.filter_gain = r_filter_gain;

    assign w_req[0].sum_angle  = r_sum_x;
    assign w_req[0].flow_angle = r_flow_x;
    assign w_req[0].bias       = r_bias_x;
    assign w_req[1].sum_angle  = r_sum_y;
    assign w_req[1].flow_angle = r_flow_y;
    assign w_req[1].bias       = r_bias_y;

    for (genvar gi = 0; gi < fgbe_pkg::NUM_LANES; gi++) begin : g_lane
        // sum_time never exceeds the 20-bit reset interval after the clear
        assign w_req[gi].dt_imu  = r_sum_time[fgbe_pkg::DT_W-1:0];
        assign w_req[gi].dt_flow = r_flow_dt;

        fgbe_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_req   (w_req[gi]),
            .i_cfg   (w_cfg),
            .o_bias  (w_lane_bias[gi]),
            .o_done  (w_lane_done[gi])
        );
    end

    // ------------------------------------------------------------------
    // Control and merge
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_time  <= '0;
            r_bias_x    <= '0;
            r_bias_y    <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (w_over) begin
                            r_sum_x    <= '0;
                            r_sum_y    <= '0;
                            r_sum_time <= '0;
                        end else begin
                            r_sum_x    <= w_add_x;
                            r_sum_y    <= w_add_y;
                            r_sum_time <= w_add_t;
                        end
                        r_flow_present <= i_flow_present;
                        r_flow_x       <= i_flow_angle_x;
                        r_flow_y       <= i_flow_angle_y;
                        r_flow_dt      <= i_flow_interval_us;
                        r_state        <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_upd <= 1'b0;
                    if (r_flow_present) begin
                        r_sum_x    <= '0;
                        r_sum_y    <= '0;
                        r_sum_time <= '0;
                    end
                    r_state <= w_start ? S_RUN : S_DONE;
                end
                S_RUN: begin
                    if (w_lane_done[0]) begin
                        r_bias_x <= w_lane_bias[0];
                        r_bias_y <= w_lane_bias[1];
                        r_upd    <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_bias_x <= r_bias_x;
                        r_out_bias_y <= r_bias_y;
                        r_out_upd    <= r_upd;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_bias_x       = r_out_bias_x;
    assign o_bias_y       = r_out_bias_y;
    assign o_bias_updated = r_out_upd;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_done[0] == w_lane_done[1])
        else $error("axis lanes finished on different cycles");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_lane_done[0] |-> r_state == S_RUN)
        else $error("lane result with no update pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == S_CHECK)
        else $error("input transfer did not start the check");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result presented outside the done state");

endmodule

// File: src/fgbe_div.sv
module fgbe_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fgbe_pkg::DIVD_W-1:0]     i_dividend,
    input  logic [fgbe_pkg::DT_W-1:0]       i_divisor,
    output logic [fgbe_pkg::DIVD_W-1:0]     o_quotient,
    output logic                            o_done
);

    logic                              r_busy;
    logic                              r_done;
    logic [fgbe_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [fgbe_pkg::DIVD_W-1:0]       r_q;
    logic [fgbe_pkg::DT_W-1:0]         r_rem;
    logic [fgbe_pkg::DT_W-1:0]         r_div;
    logic [fgbe_pkg::DIVD_W-1:0]       n_q;
    logic [fgbe_pkg::DT_W-1:0]         n_rem;

    // Restoring division, two quotient bits per cycle. Dividend bits shift
    // out of the top of r_q while quotient bits shift in at the bottom.
    always_comb begin
        logic [fgbe_pkg::DT_W:0] v_try;
        n_q   = r_q;
        n_rem = r_rem;
        v_try = '0;
        for (int k = 0; k < fgbe_pkg::DIV_BITS_PER_CYCLE; k++) begin
            v_try = {n_rem, n_q[fgbe_pkg::DIVD_W-1]};
            n_q   = {n_q[fgbe_pkg::DIVD_W-2:0], 1'b0};
            if (v_try >= {1'b0, r_div}) begin
                n_rem  = fgbe_pkg::DT_W'(v_try - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = v_try[fgbe_pkg::DT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fgbe_pkg::DIV_CNT_W'(fgbe_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

// File: src/fgbe_lane.sv
module fgbe_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  fgbe_pkg::t_lane_req                  i_req,
    input  fgbe_pkg::t_lane_cfg                  i_cfg,
    output logic signed [fgbe_pkg::BIAS_W-1:0]   o_bias,
    output logic                                 o_done
);

    localparam int RATE_W = fgbe_pkg::DIVD_W + 1;
    localparam int DIFF_W = RATE_W + 1;
    localparam int PROD_W = fgbe_pkg::GAIN_W + 1 + fgbe_pkg::BIAS_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int SHR_W  = ACC_W - 16;

    localparam logic signed [SHR_W-1:0] BIAS_MAX = SHR_W'(33554431);
    localparam logic signed [SHR_W-1:0] BIAS_MIN = -SHR_W'(33554431);
    localparam logic signed [ACC_W-1:0] HALF_Q16 = ACC_W'(32768);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_CLAMP,
        L_MUL2,
        L_SUM
    } t_lstate;

    t_lstate                              r_state;
    fgbe_pkg::t_lane_req                  r_req;
    fgbe_pkg::t_lane_cfg                  r_cfg;
    logic                                 r_div_start;
    logic                                 r_done;
    logic                                 r_imu_neg;
    logic                                 r_flow_neg;
    logic [fgbe_pkg::DIVD_W-1:0]          r_imu_prod;
    logic [fgbe_pkg::DIVD_W-1:0]          r_flow_prod;
    logic signed [RATE_W-1:0]             r_ref_rate;
    logic signed [RATE_W-1:0]             r_of_rate;
    logic signed [fgbe_pkg::BIAS_W-1:0]   r_d;
    logic signed [PROD_W-1:0]             r_p0;
    logic signed [PROD_W-1:0]             r_p1;
    logic signed [fgbe_pkg::BIAS_W-1:0]   r_bias_out;

    logic [fgbe_pkg::SUM_W-1:0]           w_imu_mag;
    logic [fgbe_pkg::FLOW_W-1:0]          w_flow_mag;
    logic [fgbe_pkg::DIVD_W-1:0]          w_imu_q;
    logic [fgbe_pkg::DIVD_W-1:0]          w_flow_q;
    logic                                 w_imu_done;
    logic                                 w_flow_done;
    logic signed [DIFF_W-1:0]             w_diff;
    logic signed [DIFF_W-1:0]             w_lim;
    logic [fgbe_pkg::GAIN_W-1:0]          w_g;
    logic [fgbe_pkg::GAIN_W-1:0]          w_gm;
    logic signed [ACC_W-1:0]              w_acc;
    logic signed [SHR_W-1:0]              w_shr;

    assign w_imu_mag  = r_req.sum_angle[fgbe_pkg::SUM_W-1]
                      ? fgbe_pkg::SUM_W'(-r_req.sum_angle) : r_req.sum_angle;
    assign w_flow_mag = r_req.flow_angle[fgbe_pkg::FLOW_W-1]
                      ? fgbe_pkg::FLOW_W'(-r_req.flow_angle) : r_req.flow_angle;

    fgbe_div u_div_imu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_imu_prod),
        .i_divisor  (r_req.dt_imu),
        .o_quotient (w_imu_q),
        .o_done     (w_imu_done)
    );

    fgbe_div u_div_flow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_flow_prod),
        .i_divisor  (r_req.dt_flow),
        .o_quotient (w_flow_q),
        .o_done     (w_flow_done)
    );

    assign w_diff = DIFF_W'(r_of_rate) - DIFF_W'(r_ref_rate);
    assign w_lim  = $signed({{(DIFF_W - fgbe_pkg::LIMIT_W){1'b0}}, r_cfg.spike_limit});

    // gains above one act as one
    assign w_g  = (r_cfg.filter_gain > fgbe_pkg::Q16_ONE) ? fgbe_pkg::Q16_ONE
                                                          : r_cfg.filter_gain;
    assign w_gm = fgbe_pkg::Q16_ONE - w_g;

    // floor of the Q16 sum with half added: round half up
    assign w_acc = ACC_W'(r_p0) + ACC_W'(r_p1) + HALF_Q16;
    assign w_shr = w_acc[ACC_W-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= L_IDLE;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_cfg   <= i_cfg;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_imu_prod  <= fgbe_pkg::DIVD_W'(w_imu_mag)
                                 * fgbe_pkg::DIVD_W'(fgbe_pkg::USEC_PER_SEC);
                    r_flow_prod <= fgbe_pkg::DIVD_W'(w_flow_mag)
                                 * fgbe_pkg::DIVD_W'(fgbe_pkg::USEC_PER_SEC);
                    r_imu_neg   <= r_req.sum_angle[fgbe_pkg::SUM_W-1];
                    r_flow_neg  <= r_req.flow_angle[fgbe_pkg::FLOW_W-1];
                    r_div_start <= 1'b1;
                    r_state     <= L_DIV;
                end
                L_DIV: begin
                    // both dividers run the same fixed number of cycles
                    if (w_imu_done) begin
                        r_ref_rate <= r_imu_neg ? -$signed({1'b0, w_imu_q})
                                                :  $signed({1'b0, w_imu_q});
                        r_of_rate  <= r_flow_neg ? -$signed({1'b0, w_flow_q})
                                                 :  $signed({1'b0, w_flow_q});
                        r_state    <= L_CLAMP;
                    end
                end
                L_CLAMP: begin
                    if (w_diff > w_lim) begin
                        r_d <= fgbe_pkg::BIAS_W'(w_lim);
                    end else if (w_diff < -w_lim) begin
                        r_d <= fgbe_pkg::BIAS_W'(-w_lim);
                    end else begin
                        r_d <= fgbe_pkg::BIAS_W'(w_diff);
                    end
                    r_state <= L_MUL2;
                end
                L_MUL2: begin
                    r_p0    <= $signed({1'b0, w_gm}) * r_req.bias;
                    r_p1    <= $signed({1'b0, w_g}) * r_d;
                    r_state <= L_SUM;
                end
                L_SUM: begin
                    if (w_shr > BIAS_MAX) begin
                        r_bias_out <= fgbe_pkg::BIAS_W'(BIAS_MAX);
                    end else if (w_shr < BIAS_MIN) begin
                        r_bias_out <= fgbe_pkg::BIAS_W'(BIAS_MIN);
                    end else begin
                        r_bias_out <= fgbe_pkg::BIAS_W'(w_shr);
                    end
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_bias = r_bias_out;
    assign o_done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_imu_done == w_flow_done)
        else $error("lane dividers out of step");

endmodule

// File: sim/tb_flow_gyro_bias_estimator.sv
`timescale 1ns / 1ps

module tb_flow_gyro_bias_estimator;
    import fgbe_pkg::*;

    localparam int     CYCLE_LIMIT = 400000;
    localparam int     HOLD_CYCLES = 400;
    localparam int     PRINT_LIMIT = 50;
    localparam longint USEC        = 1000000;
    localparam longint Q16         = 65536;
    localparam longint BIAS_LIM    = 33554431;

    localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam logic signed [ANGLE_W-1:0] ANG_MAX  = 24'sh7FFFFF;
    localparam logic signed [ANGLE_W-1:0] ANG_MIN  = 24'sh800000;
    localparam logic signed [FLOW_W-1:0]  FLOW_MAX = 26'sh1FFFFFF;
    localparam logic signed [FLOW_W-1:0]  FLOW_MIN = 26'sh2000000;

    typedef struct {
        logic signed [ANGLE_W-1:0] ang_x;
        logic signed [ANGLE_W-1:0] ang_y;
        logic [IMU_DT_W-1:0]       dt_imu;
        logic                      flow;
        logic signed [FLOW_W-1:0]  fl_x;
        logic signed [FLOW_W-1:0]  fl_y;
        logic [DT_W-1:0]           dt_flow;
    } imu_sample_t;

    typedef struct {
        logic signed [BIAS_W-1:0] bx;
        logic signed [BIAS_W-1:0] by;
        logic                     upd;
    } bias_result_t;

    // DUT signals
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [ANGLE_W-1:0]  i_imu_angle_x = '0;
    logic signed [ANGLE_W-1:0]  i_imu_angle_y = '0;
    logic [IMU_DT_W-1:0]        i_imu_interval_us = '0;
    logic                       i_flow_present = 1'b0;
    logic signed [FLOW_W-1:0]   i_flow_angle_x = '0;
    logic signed [FLOW_W-1:0]   i_flow_angle_y = '0;
    logic [DT_W-1:0]            i_flow_interval_us = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [BIAS_W-1:0]   o_bias_x;
    logic signed [BIAS_W-1:0]   o_bias_y;
    logic                       o_bias_updated;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // estimator state mirror
    logic [SUM_W-1:0]           acc_x = '0;
    logic [SUM_W-1:0]           acc_y = '0;
    logic [TIME_W-1:0]          acc_t = '0;
    logic signed [BIAS_W-1:0]   est_x = '0;
    logic signed [BIAS_W-1:0]   est_y = '0;
    logic [DT_W-1:0]            cfg_reset_int = RST_RESET_INTERVAL;
    logic [DT_W-1:0]            cfg_tol = RST_MATCH_TOL;
    logic [DT_W-1:0]            cfg_min = RST_MIN_INTERVAL;
    logic [LIMIT_W-1:0]         cfg_spike = RST_SPIKE_LIMIT;
    logic [GAIN_W-1:0]          cfg_gain = RST_FILTER_GAIN;

    bias_result_t               bias_results_q[$];
    int                         error_count = 0;
    int                         cycle_count = 0;
    logic                       tx_idle_en = 1'b1;
    logic                       rx_idle_en = 1'b1;
    logic                       hold_request = 1'b0;

    flow_gyro_bias_estimator uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_imu_angle_x      (i_imu_angle_x),
        .i_imu_angle_y      (i_imu_angle_y),
        .i_imu_interval_us  (i_imu_interval_us),
        .i_flow_present     (i_flow_present),
        .i_flow_angle_x     (i_flow_angle_x),
        .i_flow_angle_y     (i_flow_angle_y),
        .i_flow_interval_us (i_flow_interval_us),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_bias_x           (o_bias_x),
        .o_bias_y           (o_bias_y),
        .o_bias_updated     (o_bias_updated),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("flow_gyro_bias_estimator regression: fail");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // one axis of the bias filter: rate error, clamp, Q16 low-pass
    function automatic longint fold_rate_error(input longint bias, input longint sum_ang,
                                               input longint dt_imu, input longint flow_ang,
                                               input longint dt_flow);
        longint imu_rate;
        longint flow_rate;
        longint lim;
        longint g;
        longint d;
        longint nb;
        imu_rate  = (sum_ang * USEC) / dt_imu;
        flow_rate = (flow_ang * USEC) / dt_flow;
        lim = longint'(cfg_spike);
        g = (longint'(cfg_gain) > Q16) ? Q16 : longint'(cfg_gain);
        d = flow_rate - imu_rate;
        if (d > lim)
            d = lim;
        if (d < -lim)
            d = -lim;
        nb = ((Q16 - g) * bias + g * d + Q16 / 2) >>> 16;
        if (nb > BIAS_LIM)
            nb = BIAS_LIM;
        if (nb < -BIAS_LIM)
            nb = -BIAS_LIM;
        return nb;
    endfunction

    function automatic void advance_estimator(input imu_sample_t s);
        longint       gap;
        bias_result_t res;
        acc_x = acc_x + SUM_W'(s.ang_x);
        acc_y = acc_y + SUM_W'(s.ang_y);
        acc_t = acc_t + s.dt_imu;
        if (acc_t > cfg_reset_int) begin
            acc_x = '0;
            acc_y = '0;
            acc_t = '0;
        end
        res.upd = 1'b0;
        if (s.flow) begin
            gap = longint'(acc_t) - longint'(s.dt_flow);
            if (gap < 0)
                gap = -gap;
            if (gap < longint'(cfg_tol) && acc_t > cfg_min && s.dt_flow > cfg_min) begin
                est_x = fold_rate_error(est_x, $signed(acc_x), acc_t, s.fl_x, s.dt_flow);
                est_y = fold_rate_error(est_y, $signed(acc_y), acc_t, s.fl_y, s.dt_flow);
                res.upd = 1'b1;
            end
            acc_x = '0;
            acc_y = '0;
            acc_t = '0;
        end
        res.bx = est_x;
        res.by = est_y;
        bias_results_q.push_back(res);
    endfunction

    function automatic imu_sample_t mk_sample(input logic signed [ANGLE_W-1:0] ax,
                                              input logic signed [ANGLE_W-1:0] ay,
                                              input logic [IMU_DT_W-1:0] dt,
                                              input logic flow,
                                              input logic signed [FLOW_W-1:0] fx,
                                              input logic signed [FLOW_W-1:0] fy,
                                              input logic [DT_W-1:0] dtf);
        imu_sample_t s;
        s.ang_x   = ax;
        s.ang_y   = ay;
        s.dt_imu  = dt;
        s.flow    = flow;
        s.fl_x    = fx;
        s.fl_y    = fy;
        s.dt_flow = dtf;
        return s;
    endfunction

    // called right after a rising edge; returns at the transfer edge, or after a random idle gap when tx_idle_en is set
    task automatic send_sample(input imu_sample_t s);
        i_in_valid         <= 1'b1;
        i_imu_angle_x      <= s.ang_x;
        i_imu_angle_y      <= s.ang_y;
        i_imu_interval_us  <= s.dt_imu;
        i_flow_present     <= s.flow;
        i_flow_angle_x     <= s.fl_x;
        i_flow_angle_y     <= s.fl_y;
        i_flow_interval_us <= s.dt_flow;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        advance_estimator(s);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (bias_results_q.size() != 0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_RESET_INTERVAL: cfg_reset_int = value[DT_W-1:0];
            REG_MATCH_TOL:      cfg_tol       = value[DT_W-1:0];
            REG_MIN_INTERVAL:   cfg_min       = value[DT_W-1:0];
            REG_SPIKE_LIMIT:    cfg_spike     = value[LIMIT_W-1:0];
            REG_FILTER_GAIN:    cfg_gain      = value[GAIN_W-1:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [PDATA_W-1:0] reset_int, input logic [PDATA_W-1:0] tol,
                                input logic [PDATA_W-1:0] min_int, input logic [PDATA_W-1:0] spike,
                                input logic [PDATA_W-1:0] gain);
        wait_drain();
        write_reg(REG_RESET_INTERVAL, reset_int);
        write_reg(REG_MATCH_TOL, tol);
        write_reg(REG_MIN_INTERVAL, min_int);
        write_reg(REG_SPIKE_LIMIT, spike);
        write_reg(REG_FILTER_GAIN, gain);
    endtask

    // Mostly runs of IMU samples closed by a flow sample whose interval lands
    // near the accumulated time, so the match/min tests pass often.
    task automatic run_random_phase(input int n_items);
        imu_sample_t       s;
        int                sent;
        int                group;
        logic [TIME_W-1:0] t21;
        logic [SUM_W-1:0]  sx;
        logic [SUM_W-1:0]  sy;
        longint            span;
        longint            tf;
        longint            fx;
        longint            fy;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                s.ang_x   = ANGLE_W'($urandom);
                s.ang_y   = ANGLE_W'($urandom);
                s.dt_imu  = IMU_DT_W'($urandom);
                s.flow    = 1'($urandom);
                s.fl_x    = FLOW_W'($urandom);
                s.fl_y    = FLOW_W'($urandom);
                s.dt_flow = DT_W'($urandom);
                send_sample(s);
                sent++;
            end else begin
                group = $urandom_range(1, 16);
                for (int k = 0; k < group; k++) begin
                    s.ang_x   = ANGLE_W'($urandom);
                    s.ang_x   = s.ang_x >>> $urandom_range(0, 20);
                    s.ang_y   = ANGLE_W'($urandom);
                    s.ang_y   = s.ang_y >>> $urandom_range(0, 20);
                    s.dt_imu  = $urandom_range(100, 4000);
                    s.flow    = (k == group - 1) || ($urandom_range(0, 49) == 0);
                    s.fl_x    = FLOW_W'($urandom);
                    s.fl_y    = FLOW_W'($urandom);
                    s.dt_flow = DT_W'($urandom);
                    if (s.flow) begin
                        t21 = acc_t + s.dt_imu;
                        sx  = acc_x + SUM_W'(s.ang_x);
                        sy  = acc_y + SUM_W'(s.ang_y);
                        if (t21 > cfg_reset_int) begin
                            t21 = '0;
                            sx  = '0;
                            sy  = '0;
                        end
                        span = longint'(cfg_tol) + longint'(cfg_tol) / 8 + 2;
                        tf = longint'(t21) + longint'($urandom_range(0, 2 * span)) - span;
                        if (tf < 0)
                            tf = 0;
                        if (tf > 20'hFFFFF)
                            tf = 20'hFFFFF;
                        s.dt_flow = DT_W'(tf);
                        // flow angle tracks the IMU sum plus a noise term of random size
                        fx = longint'($signed(sx)) + longint'(s.fl_x >>> $urandom_range(4, 25));
                        fy = longint'($signed(sy)) + longint'(s.fl_y >>> $urandom_range(4, 25));
                        if (fx > longint'(FLOW_MAX))
                            fx = FLOW_MAX;
                        if (fx < longint'(FLOW_MIN))
                            fx = FLOW_MIN;
                        if (fy > longint'(FLOW_MAX))
                            fy = FLOW_MAX;
                        if (fy < longint'(FLOW_MIN))
                            fy = FLOW_MIN;
                        s.fl_x = FLOW_W'(fx);
                        s.fl_y = FLOW_W'(fy);
                    end
                    send_sample(s);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_sample_extremes();
        send_sample(mk_sample(ANG_MAX, ANG_MIN, 16'hFFFF, 1'b0, FLOW_MIN, FLOW_MAX, 20'hFFFFF));
        send_sample(mk_sample(ANG_MIN, ANG_MAX, 16'd0, 1'b0, '0, '0, '0));
        // large flow rates, clamped at the spike limit
        send_sample(mk_sample(1000, -1000, 16'd0, 1'b1, FLOW_MAX, FLOW_MIN, 20'd66535));
        // difference equal to the tolerance: rejected
        send_sample(mk_sample(500, -500, 16'd20000, 1'b1, 1000, 2000, 20'd70000));
        send_sample(mk_sample(-70, 90, 16'd60000, 1'b1, -300000, 400000, 20'd10001));
        // intervals equal to the minimum: rejected
        send_sample(mk_sample(5, 5, 16'd10000, 1'b1, 10, 10, 20'd10000));
        send_sample(mk_sample(5, 5, 16'd10001, 1'b1, 7, -7, 20'd10001));
        send_sample(mk_sample(5, 5, 16'd5, 1'b1, '0, '0, '0));
    endtask

    task automatic test_interval_reset();
        wait_drain();
        write_reg(REG_RESET_INTERVAL, 32'd100000);
        send_sample(mk_sample(3000, -3000, 16'd60000, 1'b0, '0, '0, '0));
        send_sample(mk_sample(3000, -3000, 16'd60000, 1'b0, '0, '0, '0));
        send_sample(mk_sample(20, 40, 16'd20000, 1'b1, 40, -80, 20'd20000));
        // sum equal to the limit is kept
        send_sample(mk_sample(-9000, 7000, 16'd50000, 1'b0, '0, '0, '0));
        send_sample(mk_sample(-9000, 7000, 16'd50000, 1'b1, -30000, 20000, 20'd100001));
        wait_drain();
        write_reg(REG_RESET_INTERVAL, RST_RESET_INTERVAL);
    endtask

    task automatic test_zero_intervals();
        wait_drain();
        write_reg(REG_MIN_INTERVAL, 32'd0);
        write_reg(REG_MATCH_TOL, 32'hFFFFF);
        send_sample(mk_sample(9, 9, 16'd0, 1'b1, 5, 5, 20'd0));
        send_sample(mk_sample(ANG_MAX, ANG_MIN, 16'd1, 1'b1, FLOW_MIN, FLOW_MAX, 20'd1));
        send_sample(mk_sample(3, 3, 16'd0, 1'b1, 5, 5, 20'd7));
    endtask

    task automatic test_register_extremes();
        apply_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(mk_sample(100, 100, 16'd0, 1'b0, '0, '0, '0));
        send_sample(mk_sample(100, 100, 16'd7, 1'b1, 9, 9, 20'd7));
        // zero gain: the filter holds its value; the zero reset interval clears the sum, so the update is rejected
        wait_drain();
        write_reg(REG_MATCH_TOL, 32'hFFFFF);
        send_sample(mk_sample(-400, 300, 16'd5, 1'b1, 900, -900, 20'd5));
        // all-ones writes: fields truncate, gain saturates at one
        apply_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        write_reg(REG_NONE, 32'h0);
        send_sample(mk_sample(1, 1, 16'd40000, 1'b1, 2, 2, 20'd40000));
        wait_drain();
        write_reg(REG_MIN_INTERVAL, 32'd0);
        send_sample(mk_sample(ANG_MIN, ANG_MAX, 16'd1, 1'b1, FLOW_MAX, FLOW_MIN, 20'd1));
    endtask

    task automatic test_output_backpressure();
        apply_config(RST_RESET_INTERVAL, RST_MATCH_TOL, RST_MIN_INTERVAL, RST_SPIKE_LIMIT,
                     RST_FILTER_GAIN);
        hold_request <= 1'b1;
        run_random_phase(12);
        wait_drain();
        run_random_phase(20);
    endtask

    task automatic test_sum_wrap();
        apply_config(32'hFFFFF, 32'hFFFFF, 32'd0, 32'h1FFFFFF, 32'd65536);
        for (int n = 0; n < 300; n++)
            send_sample(mk_sample(ANG_MAX, ANG_MIN, 16'd1, 1'b0, '0, '0, '0));
        send_sample(mk_sample(ANG_MAX, ANG_MIN, 16'd1, 1'b1, 1000, -1000, 20'd301));
    endtask

    task automatic test_random_regression();
        apply_config(RST_RESET_INTERVAL, RST_MATCH_TOL, RST_MIN_INTERVAL, RST_SPIKE_LIMIT,
                     RST_FILTER_GAIN);
        run_random_phase(170);
        apply_config(32'hFFFFF, 32'hFFFFF, 32'd0, 32'h1FFFFFF, 32'h1FFFF);
        run_random_phase(150);
        apply_config(32'd30000, 32'd1500, 32'd3000, 32'd2000, 32'd65536);
        run_random_phase(150);
        for (int p = 0; p < 3; p++) begin
            tx_idle_en = (p != 1);
            rx_idle_en <= (p != 0);
            apply_config($urandom_range(20000, 20'hFFFFF), $urandom_range(500, 80000),
                         $urandom_range(0, 20000), $urandom_range(0, 25'h1FFFFFF),
                         $urandom_range(0, 17'h1FFFF));
            run_random_phase(150);
        end
        // closing stretch at full rate
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        apply_config($urandom_range(20000, 20'hFFFFF), $urandom_range(500, 80000),
                     $urandom_range(0, 20000), $urandom_range(0, 25'h1FFFFFF),
                     $urandom_range(0, 17'h1FFFF));
        run_random_phase(170);
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_ready  <= 1'b0;
                hold_request <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 4))
                    @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        bias_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (bias_results_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer bias %0d/%0d upd %0b",
                                        o_bias_x, o_bias_y, o_bias_updated));
            end else begin
                want = bias_results_q.pop_front();
                if (o_bias_x !== want.bx)
                    flag_mismatch($sformatf("bias_x got %0d want %0d", o_bias_x, want.bx));
                if (o_bias_y !== want.by)
                    flag_mismatch($sformatf("bias_y got %0d want %0d", o_bias_y, want.by));
                if (o_bias_updated !== want.upd)
                    flag_mismatch($sformatf("bias_updated got %0b want %0b",
                                            o_bias_updated, want.upd));
            end
        end
    end

    initial begin
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sample_extremes();
        test_interval_reset();
        test_zero_intervals();
        test_register_extremes();
        test_output_backpressure();
        test_sum_wrap();
        test_random_regression();
        wait_drain();
        repeat (60)
            @(posedge i_clk);
        if (error_count == 0)
            $display("flow_gyro_bias_estimator regression: pass");
        else
            $display("flow_gyro_bias_estimator regression: fail");
        $finish;
    end

endmodule
